// ===== rtl/core/paws_pkg.sv =====
// Shared constants and the arctangent table for the particle attractor step.
package paws_pkg;

    localparam int ITERS    = 18;
    localparam int Z_W      = 24;
    localparam int V1_W     = 32;
    localparam int ROT_W    = 34;
    localparam int V2_W     = 36;
    localparam int POS_W    = 18;
    localparam int MOV_W    = 22;
    localparam int NSTAGES  = 3 * ITERS + 5;

    localparam logic [15:0] INV_GAIN = 16'd39797;

    localparam logic [7:0] CFG_GAIN      = 8'd0;
    localparam logic [7:0] CFG_MAX_SPEED = 8'd1;
    localparam logic [7:0] CFG_WIDTH     = 8'd2;
    localparam logic [7:0] CFG_HEIGHT    = 8'd3;

    // arctan(2^-i) in 2^-20 turn
    function automatic logic [17:0] atan_of(input int i);
        logic [17:0] r;
        case (i)
            0:       r = 18'd131072;
            1:       r = 18'd77376;
            2:       r = 18'd40884;
            3:       r = 18'd20753;
            4:       r = 18'd10417;
            5:       r = 18'd5213;
            6:       r = 18'd2607;
            7:       r = 18'd1304;
            8:       r = 18'd652;
            9:       r = 18'd326;
            10:      r = 18'd163;
            11:      r = 18'd81;
            12:      r = 18'd41;
            13:      r = 18'd20;
            14:      r = 18'd10;
            15:      r = 18'd5;
            16:      r = 18'd3;
            17:      r = 18'd1;
            default: r = 18'd0;
        endcase
        return r;
    endfunction

endpackage

// ===== rtl/core/paws_cordic_cell.sv =====
// One registered CORDIC micro-rotation, vectoring or rotating.
module paws_cordic_cell #(
    parameter int W      = 32,
    parameter int ZW     = 24,
    parameter int SHIFT  = 0,
    parameter bit VECTOR = 1'b1
) (
    input  logic                 clk,
    input  logic                 en,
    input  logic signed [W-1:0]  x_in,
    input  logic signed [W-1:0]  y_in,
    input  logic signed [ZW-1:0] z_in,
    output logic signed [W-1:0]  x_out,
    output logic signed [W-1:0]  y_out,
    output logic signed [ZW-1:0] z_out
);

    logic signed [W-1:0]  sx;
    logic signed [W-1:0]  sy;
    logic signed [ZW-1:0] ang;
    logic                 up;
    logic signed [W-1:0]  x_reg, x_next;
    logic signed [W-1:0]  y_reg, y_next;
    logic signed [ZW-1:0] z_reg, z_next;

    assign sx  = x_in >>> SHIFT;
    assign sy  = y_in >>> SHIFT;
    assign ang = $signed(ZW'(paws_pkg::atan_of(SHIFT)));

    always_comb
    begin
        if (VECTOR)
        begin
            up     = !y_in[W-1];
            x_next = up ? (x_in + sy) : (x_in - sy);
            y_next = up ? (y_in - sx) : (y_in + sx);
            z_next = up ? (z_in + ang) : (z_in - ang);
        end
        else
        begin
            up     = !z_in[ZW-1];
            x_next = up ? (x_in - sy) : (x_in + sy);
            y_next = up ? (y_in + sx) : (y_in - sx);
            z_next = up ? (z_in - ang) : (z_in + ang);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x_reg <= x_next;
            y_reg <= y_next;
            z_reg <= z_next;
        end
    end

    assign x_out = x_reg;
    assign y_out = y_reg;
    assign z_out = z_reg;

endmodule

// ===== rtl/core/particle_attract_wrap_step.sv =====
// Top level of the particle attractor step with toroidal wrap.
// Usage: present one particle per transfer on the input channel (in_valid/in_ready)
// with the cursor position and two jitter values; the updated position, heading and
// speed leave on the output channel (out_valid/out_ready), one result per particle,
// in order.
// Throughput is one particle per cycle when the output is not stalled: three chains
// of 18 CORDIC cells (direction to cursor together with the velocity rotation, then
// the pull rotation, then the final vectoring) and five glue stages (three setup
// stages, gain compensation, output register) form one pipeline that advances as a
// whole.
// When the receiver stalls, the result holds in the output register and the whole
// pipeline freezes; in_ready follows (!out_valid || out_ready).
// Reset empties the pipeline and loads the registers with their defaults
// (gain 512, max speed 5120, area 700 x 700). Write registers over cfg_we/cfg_index/
// cfg_data only while no particle is in flight.
module particle_attract_wrap_step (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [17:0]        pos_x,
    input  logic [17:0]        pos_y,
    input  logic [15:0]        heading,
    input  logic [15:0]        speed,
    input  logic signed [19:0] cursor_x,
    input  logic signed [19:0] cursor_y,
    input  logic [7:0]         jitter_x,
    input  logic [7:0]         jitter_y,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [17:0]        new_pos_x,
    output logic [17:0]        new_pos_y,
    output logic [15:0]        new_heading,
    output logic [15:0]        new_speed,
    input  logic               cfg_we,
    input  logic [7:0]         cfg_index,
    input  logic [15:0]        cfg_data
);

    localparam int N  = paws_pkg::ITERS;
    localparam int ZW = paws_pkg::Z_W;
    localparam int W1 = paws_pkg::V1_W;
    localparam int WR = paws_pkg::ROT_W;
    localparam int W2 = paws_pkg::V2_W;
    localparam int MW = paws_pkg::MOV_W;
    localparam int NS = paws_pkg::NSTAGES;
    localparam int POS_W_C = paws_pkg::POS_W;

    // configuration
    logic [15:0] gain_reg;
    logic [15:0] max_speed_reg;
    logic [9:0]  width_reg;
    logic [9:0]  height_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gain_reg      <= 16'd512;
            max_speed_reg <= 16'd5120;
            width_reg     <= 10'd700;
            height_reg    <= 10'd700;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                paws_pkg::CFG_GAIN:      gain_reg      <= cfg_data;
                paws_pkg::CFG_MAX_SPEED: max_speed_reg <= cfg_data;
                paws_pkg::CFG_WIDTH:     width_reg     <= cfg_data[9:0];
                paws_pkg::CFG_HEIGHT:    height_reg    <= cfg_data[9:0];
                default: ;
            endcase
        end
    end

    // pipeline control
    logic          adv;
    logic [NS-1:0] vld_reg;

    assign adv       = !vld_reg[NS-1] || out_ready;
    assign in_ready  = adv;
    assign out_valid = vld_reg[NS-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (adv)
            vld_reg <= {vld_reg[NS-2:0], in_valid};
    end

    function automatic logic [15:0] angle_of(input logic signed [ZW-1:0] acc);
        logic signed [ZW-1:0] t;
        t = acc + ZW'(8);
        return t[19:4];
    endfunction

    function automatic logic [POS_W_C-1:0] wrap_axis(input logic signed [MW-1:0] p,
                                                     input logic [9:0] size);
        logic signed [MW:0] s;
        logic signed [MW:0] q;
        s = $signed({{(MW-17){1'b0}}, size, 8'h00});
        q = {p[MW-1], p};
        if (q > s - (MW+1)'(256))
            q = q - s;
        else if (q < 0)
            q = q + s;
        if (q < 0)
            q = '0;
        if (q > (MW+1)'(262143))
            q = (MW+1)'(262143);
        return q[POS_W_C-1:0];
    endfunction

    // ---------------- stage P0: set up direction vector and velocity rotation
    logic signed [20:0] dx21, dy21;
    logic signed [W1-1:0] dxe, dye;
    logic [31:0] vmul;
    logic        hq;
    logic [15:0] hfold;

    assign dx21 = {cursor_x[19], cursor_x} - $signed({3'b000, pos_x});
    assign dy21 = {cursor_y[19], cursor_y} - $signed({3'b000, pos_y});
    assign dxe  = W1'(dx21) <<< 8;
    assign dye  = W1'(dy21) <<< 8;
    assign vmul = speed * paws_pkg::INV_GAIN;
    assign hq   = heading[15] ^ heading[14];
    assign hfold = hq ? (heading - 16'h8000) : heading;

    logic signed [W1-1:0] a1x [0:N];
    logic signed [W1-1:0] a1y [0:N];
    logic signed [ZW-1:0] a1z [0:N];
    logic signed [WR-1:0] avx [0:N];
    logic signed [WR-1:0] avy [0:N];
    logic signed [ZW-1:0] avz [0:N];
    logic [17:0]          apx_reg [0:N];
    logic [17:0]          apy_reg [0:N];
    logic [7:0]           ajx_reg [0:N];
    logic [7:0]           ajy_reg [0:N];
    logic                 az_reg  [0:N];
    logic signed [W1-1:0] p0x_reg, p0y_reg;
    logic signed [ZW-1:0] p0z_reg;
    logic signed [WR-1:0] p0vx_reg;
    logic signed [ZW-1:0] p0vz_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            p0x_reg     <= dx21[20] ? -dxe : dxe;
            p0y_reg     <= dx21[20] ? -dye : dye;
            p0z_reg     <= dx21[20] ? ZW'(1 << 19) : '0;
            p0vx_reg    <= hq ? -$signed(WR'(vmul >> 2)) : $signed(WR'(vmul >> 2));
            p0vz_reg    <= $signed({{(ZW-20){hfold[15]}}, hfold, 4'h0});
            apx_reg[0]  <= pos_x;
            apy_reg[0]  <= pos_y;
            ajx_reg[0]  <= jitter_x;
            ajy_reg[0]  <= jitter_y;
            az_reg[0]   <= (dx21 == '0) && (dy21 == '0);
        end
    end

    assign a1x[0] = p0x_reg;
    assign a1y[0] = p0y_reg;
    assign a1z[0] = p0z_reg;
    assign avx[0] = p0vx_reg;
    assign avy[0] = '0;
    assign avz[0] = p0vz_reg;

    // ---------------- chain A: direction to cursor and velocity components
    for (genvar i = 0; i < N; i++)
    begin : g_chain_a
        paws_cordic_cell #(.W(W1), .ZW(ZW), .SHIFT(i), .VECTOR(1'b1)) u_dir (
            .clk(clk), .en(adv),
            .x_in(a1x[i]), .y_in(a1y[i]), .z_in(a1z[i]),
            .x_out(a1x[i+1]), .y_out(a1y[i+1]), .z_out(a1z[i+1])
        );
        paws_cordic_cell #(.W(WR), .ZW(ZW), .SHIFT(i), .VECTOR(1'b0)) u_vel (
            .clk(clk), .en(adv),
            .x_in(avx[i]), .y_in(avy[i]), .z_in(avz[i]),
            .x_out(avx[i+1]), .y_out(avy[i+1]), .z_out(avz[i+1])
        );
        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                apx_reg[i+1] <= apx_reg[i];
                apy_reg[i+1] <= apy_reg[i];
                ajx_reg[i+1] <= ajx_reg[i];
                ajy_reg[i+1] <= ajy_reg[i];
                az_reg[i+1]  <= az_reg[i];
            end
        end
    end

    // ---------------- stage P1: set up pull rotation
    logic [15:0] pull_ang, pfold;
    logic        pq;
    logic [31:0] gmul;

    assign pull_ang = az_reg[N] ? 16'h0000 : angle_of(a1z[N]);
    assign pq       = pull_ang[15] ^ pull_ang[14];
    assign pfold    = pq ? (pull_ang - 16'h8000) : pull_ang;
    assign gmul     = gain_reg * paws_pkg::INV_GAIN;

    logic signed [WR-1:0] bx [0:N];
    logic signed [WR-1:0] by [0:N];
    logic signed [ZW-1:0] bz [0:N];
    logic signed [WR-1:0] bvx_reg [0:N];
    logic signed [WR-1:0] bvy_reg [0:N];
    logic [17:0]          bpx_reg [0:N];
    logic [17:0]          bpy_reg [0:N];
    logic [7:0]           bjx_reg [0:N];
    logic [7:0]           bjy_reg [0:N];
    logic signed [WR-1:0] p1x_reg;
    logic signed [ZW-1:0] p1z_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            p1x_reg    <= pq ? -$signed(WR'(gmul >> 2)) : $signed(WR'(gmul >> 2));
            p1z_reg    <= $signed({{(ZW-20){pfold[15]}}, pfold, 4'h0});
            bvx_reg[0] <= avx[N];
            bvy_reg[0] <= avy[N];
            bpx_reg[0] <= apx_reg[N];
            bpy_reg[0] <= apy_reg[N];
            bjx_reg[0] <= ajx_reg[N];
            bjy_reg[0] <= ajy_reg[N];
        end
    end

    assign bx[0] = p1x_reg;
    assign by[0] = '0;
    assign bz[0] = p1z_reg;

    // ---------------- chain B: pull components
    for (genvar i = 0; i < N; i++)
    begin : g_chain_b
        paws_cordic_cell #(.W(WR), .ZW(ZW), .SHIFT(i), .VECTOR(1'b0)) u_pull (
            .clk(clk), .en(adv),
            .x_in(bx[i]), .y_in(by[i]), .z_in(bz[i]),
            .x_out(bx[i+1]), .y_out(by[i+1]), .z_out(bz[i+1])
        );
        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                bvx_reg[i+1] <= bvx_reg[i];
                bvy_reg[i+1] <= bvy_reg[i];
                bpx_reg[i+1] <= bpx_reg[i];
                bpy_reg[i+1] <= bpy_reg[i];
                bjx_reg[i+1] <= bjx_reg[i];
                bjy_reg[i+1] <= bjy_reg[i];
            end
        end
    end

    // ---------------- stage P2: sum velocities, move, set up final vectoring
    logic signed [WR-1:0] sum_x, sum_y, rnd_x, rnd_y;
    logic signed [W2-1:0] sxe, sye;
    logic signed [MW-1:0] mov_x, mov_y;

    assign sum_x = bvx_reg[N] + bx[N];
    assign sum_y = bvy_reg[N] + by[N];
    assign sxe   = W2'(sum_x);
    assign sye   = W2'(sum_y);
    assign rnd_x = (sum_x + WR'(8192)) >>> 14;
    assign rnd_y = (sum_y + WR'(8192)) >>> 14;
    assign mov_x = $signed(MW'(bpx_reg[N])) + rnd_x[MW-1:0] + $signed(MW'(bjx_reg[N]));
    assign mov_y = $signed(MW'(bpy_reg[N])) + rnd_y[MW-1:0] + $signed(MW'(bjy_reg[N]));

    logic signed [W2-1:0] cx [0:N];
    logic signed [W2-1:0] cy [0:N];
    logic signed [ZW-1:0] cz [0:N];
    logic signed [MW-1:0] cmx_reg [0:N];
    logic signed [MW-1:0] cmy_reg [0:N];
    logic                 czr_reg [0:N];
    logic signed [W2-1:0] p2x_reg, p2y_reg;
    logic signed [ZW-1:0] p2z_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            p2x_reg    <= sum_x[WR-1] ? -sxe : sxe;
            p2y_reg    <= sum_x[WR-1] ? -sye : sye;
            p2z_reg    <= sum_x[WR-1] ? ZW'(1 << 19) : '0;
            cmx_reg[0] <= mov_x;
            cmy_reg[0] <= mov_y;
            czr_reg[0] <= (sum_x == '0) && (sum_y == '0);
        end
    end

    assign cx[0] = p2x_reg;
    assign cy[0] = p2y_reg;
    assign cz[0] = p2z_reg;

    // ---------------- chain C: magnitude and angle of the summed velocity
    for (genvar i = 0; i < N; i++)
    begin : g_chain_c
        paws_cordic_cell #(.W(W2), .ZW(ZW), .SHIFT(i), .VECTOR(1'b1)) u_sum (
            .clk(clk), .en(adv),
            .x_in(cx[i]), .y_in(cy[i]), .z_in(cz[i]),
            .x_out(cx[i+1]), .y_out(cy[i+1]), .z_out(cz[i+1])
        );
        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                cmx_reg[i+1] <= cmx_reg[i];
                cmy_reg[i+1] <= cmy_reg[i];
                czr_reg[i+1] <= czr_reg[i];
            end
        end
    end

    // ---------------- stage P3: gain compensation as two partial products
    logic [W2-1:0] mag_c;
    logic [35:0]   hi_prod_reg;
    logic [31:0]   lo_prod_reg;
    logic [15:0]   ang_reg;
    logic signed [MW-1:0] p3mx_reg, p3my_reg;

    assign mag_c = (czr_reg[N] || cx[N][W2-1]) ? '0 : cx[N];

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            hi_prod_reg <= mag_c[W2-1:16] * paws_pkg::INV_GAIN;
            lo_prod_reg <= mag_c[15:0] * paws_pkg::INV_GAIN;
            ang_reg     <= czr_reg[N] ? 16'h0000 : angle_of(cz[N]);
            p3mx_reg    <= cmx_reg[N];
            p3my_reg    <= cmy_reg[N];
        end
    end

    // ---------------- stage P4: round, clamp speed, wrap position
    logic [36:0] mag_k;
    logic [36:0] spd_r;
    logic [15:0] spd_sat;
    logic [17:0] new_pos_x_reg, new_pos_y_reg;
    logic [15:0] new_heading_reg, new_speed_reg;

    assign mag_k   = 37'(hi_prod_reg) + 37'(lo_prod_reg >> 16);
    assign spd_r   = (mag_k + 37'd8192) >> 14;
    assign spd_sat = (spd_r > 37'd65535) ? 16'hFFFF : spd_r[15:0];

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            new_pos_x_reg   <= wrap_axis(p3mx_reg, width_reg);
            new_pos_y_reg   <= wrap_axis(p3my_reg, height_reg);
            new_heading_reg <= ang_reg;
            new_speed_reg   <= (spd_sat > max_speed_reg) ? max_speed_reg : spd_sat;
        end
    end

    assign new_pos_x   = new_pos_x_reg;
    assign new_pos_y   = new_pos_y_reg;
    assign new_heading = new_heading_reg;
    assign new_speed   = new_speed_reg;

endmodule

// ===== rtl/core/paws_checker.sv =====
// Port-level checks for the particle attractor step, bound to the top level.
module paws_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic [17:0] new_pos_x,
    input logic [17:0] new_pos_y,
    input logic [15:0] new_heading,
    input logic [15:0] new_speed
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(new_pos_x) && $stable(new_pos_y)
            && $stable(new_heading) && $stable(new_speed))
        else $error("stalled result changed");

    // an empty output register never blocks the input
    a_ready_free: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("input blocked with output empty");

    // a stalled output freezes the pipeline
    a_ready_stall: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |-> !in_ready)
        else $error("input taken while pipeline frozen");

    // hold an offered particle until its transfer
    a_stall_no_take: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_ready |=> in_valid)
        else $error("input dropped while stalled");

endmodule

bind particle_attract_wrap_step paws_checker u_paws_checker (.*);
